### src/bhpc_pkg.sv
package bhpc_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [CfgIdxWidth-1:0] REG_ARRIVAL_TIME          = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_DEPARTURE_TIME        = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_PRESENCE_TARGET       = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_STANDBY_TARGET        = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_STANDBY_NIGHT_TARGET  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_HYSTERESIS            = 3'd5;
  localparam logic [CfgIdxWidth-1:0] REG_PUMP_ON_FLUID_TEMP    = 3'd6;
  localparam logic [CfgIdxWidth-1:0] REG_HEATER_OFF_FLUID_TEMP = 3'd7;

  localparam logic signed [11:0] RST_PRESENCE_TARGET       = 12'sd320;
  localparam logic signed [11:0] RST_STANDBY_TARGET        = 12'sd128;
  localparam logic signed [11:0] RST_STANDBY_NIGHT_TARGET  = 12'sd128;
  localparam logic [10:0]        RST_HYSTERESIS            = 11'd8;
  localparam logic signed [11:0] RST_PUMP_ON_FLUID_TEMP    = 12'sd640;
  localparam logic signed [11:0] RST_HEATER_OFF_FLUID_TEMP = 12'sd960;

  // 95 degrees in sixteenths, and 0.5 degree per hour as seconds per sixteenth.
  localparam logic signed [11:0] OVERHEAT_LIMIT        = 12'sd1520;
  localparam logic signed [9:0]  SECONDS_PER_SIXTEENTH = 10'sd450;
  localparam logic [4:0]         NIGHT_END_HOUR        = 5'd8;

  typedef struct packed {
    logic [31:0]        now_seconds;
    logic [4:0]         hour_of_day;
    logic signed [11:0] control_temp;
    logic signed [11:0] heater_temp;
    logic signed [11:0] fluid_temp;
  } in_item_t;

  typedef struct packed {
    logic               heater_on;
    logic               pump_on;
    logic               overheat_fault;
    logic               presence_mode;
    logic signed [11:0] target_temp;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        arrival_time;
    logic [31:0]        departure_time;
    logic signed [11:0] presence_target;
    logic signed [11:0] standby_target;
    logic signed [11:0] standby_night_target;
    logic [10:0]        hysteresis;
    logic signed [11:0] pump_on_fluid_temp;
    logic signed [11:0] heater_off_fluid_temp;
  } cfg_t;

  typedef struct packed {
    logic fault;
    logic heater;
    logic pump;
  } ctrl_status_t;

endpackage

### src/bhpc_cfg.sv
module bhpc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bhpc_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [bhpc_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  output bhpc_pkg::cfg_t                      cfg_o
);

  bhpc_pkg::cfg_t cfg_q;
  bhpc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bhpc_pkg::REG_ARRIVAL_TIME:          cfg_d.arrival_time = cfg_wdata_i;
        bhpc_pkg::REG_DEPARTURE_TIME:        cfg_d.departure_time = cfg_wdata_i;
        bhpc_pkg::REG_PRESENCE_TARGET:       cfg_d.presence_target = cfg_wdata_i[11:0];
        bhpc_pkg::REG_STANDBY_TARGET:        cfg_d.standby_target = cfg_wdata_i[11:0];
        bhpc_pkg::REG_STANDBY_NIGHT_TARGET:  cfg_d.standby_night_target = cfg_wdata_i[11:0];
        bhpc_pkg::REG_HYSTERESIS:            cfg_d.hysteresis = cfg_wdata_i[10:0];
        bhpc_pkg::REG_PUMP_ON_FLUID_TEMP:    cfg_d.pump_on_fluid_temp = cfg_wdata_i[11:0];
        bhpc_pkg::REG_HEATER_OFF_FLUID_TEMP: cfg_d.heater_off_fluid_temp = cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arrival_time          <= '0;
      cfg_q.departure_time        <= '0;
      cfg_q.presence_target       <= bhpc_pkg::RST_PRESENCE_TARGET;
      cfg_q.standby_target        <= bhpc_pkg::RST_STANDBY_TARGET;
      cfg_q.standby_night_target  <= bhpc_pkg::RST_STANDBY_NIGHT_TARGET;
      cfg_q.hysteresis            <= bhpc_pkg::RST_HYSTERESIS;
      cfg_q.pump_on_fluid_temp    <= bhpc_pkg::RST_PUMP_ON_FLUID_TEMP;
      cfg_q.heater_off_fluid_temp <= bhpc_pkg::RST_HEATER_OFF_FLUID_TEMP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/bhpc_ctrl.sv
module bhpc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  bhpc_pkg::in_item_t     item_i,
  input  bhpc_pkg::cfg_t         cfg_i,
  output bhpc_pkg::out_item_t    result_o,
  output bhpc_pkg::ctrl_status_t status_o
);

  logic heater_q, heater_d;
  logic pump_q, pump_d;
  logic fault_q, fault_d;

  logic signed [12:0] temp_gap;
  logic signed [22:0] lead_time;
  logic signed [33:0] start_time;
  logic signed [33:0] now_ext;
  logic signed [33:0] departure_ext;
  logic               in_window;
  logic signed [11:0] target;
  logic signed [13:0] upper_band;
  logic signed [13:0] ctl_ext;

  always_comb begin
    temp_gap      = {cfg_i.presence_target[11], cfg_i.presence_target}
                  - {item_i.control_temp[11], item_i.control_temp};
    lead_time     = temp_gap * bhpc_pkg::SECONDS_PER_SIXTEENTH;
    start_time    = $signed({2'b00, cfg_i.arrival_time}) - 34'(lead_time);
    now_ext       = $signed({2'b00, item_i.now_seconds});
    departure_ext = $signed({2'b00, cfg_i.departure_time});
    in_window     = (now_ext >= start_time) && (now_ext <= departure_ext);

    if (in_window) begin
      target = cfg_i.presence_target;
    end else if (item_i.hour_of_day < bhpc_pkg::NIGHT_END_HOUR) begin
      target = cfg_i.standby_night_target;
    end else begin
      target = cfg_i.standby_target;
    end

    upper_band = {{2{target[11]}}, target} + $signed({3'b000, cfg_i.hysteresis});
    ctl_ext    = {{2{item_i.control_temp[11]}}, item_i.control_temp};

    fault_d  = fault_q || (item_i.heater_temp > bhpc_pkg::OVERHEAT_LIMIT);
    heater_d = heater_q;
    pump_d   = pump_q;

    if (!fault_d) begin
      if (item_i.fluid_temp > cfg_i.heater_off_fluid_temp) begin
        heater_d = 1'b0;
      end else if (item_i.control_temp < target) begin
        heater_d = 1'b1;
        pump_d   = 1'b1;
      end else if (ctl_ext > upper_band) begin
        heater_d = 1'b0;
      end

      if (!heater_d && (item_i.fluid_temp < cfg_i.pump_on_fluid_temp)) begin
        pump_d = 1'b0;
      end else if (item_i.fluid_temp >= cfg_i.pump_on_fluid_temp) begin
        pump_d = 1'b1;
      end
    end

    result_o.heater_on      = heater_d;
    result_o.pump_on        = pump_d;
    result_o.overheat_fault = fault_d;
    result_o.presence_mode  = !fault_d && in_window;
    result_o.target_temp    = fault_d ? 12'sd0 : target;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q <= 1'b0;
      pump_q   <= 1'b0;
      fault_q  <= 1'b0;
    end else if (step_i) begin
      heater_q <= heater_d;
      pump_q   <= pump_d;
      fault_q  <= fault_d;
    end
  end

  assign status_o.fault  = fault_q;
  assign status_o.heater = heater_q;
  assign status_o.pump   = pump_q;

endmodule

### src/boiler_heater_pump_controller_top.sv
// Boiler heater and pump controller with a hysteresis thermostat.
// Sensor ticks enter on the in channel (valid/ready) as one in_item_t
// transaction; each tick yields exactly one out_item_t transaction on the
// out channel with the relay commands, the fault flag, the presence flag
// and the chosen target.
// Throughput is one tick per cycle while the receiver does not stall. A tick
// accepted at a clock edge lands in the input register, is evaluated
// combinationally against the relay state and the configuration, and its
// result is registered in the output register when the tick advances.
// The configuration port writes one register per cycle when cfg_we_i is
// high; it should only be used while no tick is in flight.
// Reset clears both relays and the overheat fault, empties both stages and
// loads the default configuration. Only reset clears a latched fault.
// When the receiver stalls, the result waits in the output register and one
// more tick can be held in the input register; in_ready_o falls only when
// both are full and out_ready_i is low.
module boiler_heater_pump_controller_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bhpc_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bhpc_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [bhpc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [bhpc_pkg::CfgDataWidth-1:0] cfg_wdata_i
);

  logic                   in_valid_q;
  bhpc_pkg::in_item_t     in_data_q;
  logic                   out_valid_q;
  bhpc_pkg::out_item_t    out_data_q;
  logic                   advance;
  bhpc_pkg::cfg_t         cfg;
  bhpc_pkg::out_item_t    result;
  bhpc_pkg::ctrl_status_t status;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  bhpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bhpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_data_q),
    .cfg_i    (cfg),
    .result_o (result),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_fault_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fault |=> status.fault)
    else $error("overheat fault cleared without reset");

  a_heater_needs_pump : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.heater |-> status.pump)
    else $error("heater relay on while pump relay off");

  a_fault_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overheat_fault) |->
      (!out_data_o.presence_mode && (out_data_o.target_temp == 12'sd0)))
    else $error("faulted result carries presence or target");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a stage is free");

endmodule
